// ----- rtl/core/assert_macros.svh -----
// assertion macro included by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge, quiet while in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- rtl/core/hsa_pkg.sv -----
// types and constants for the handle slot allocator
package hsa_pkg;

    localparam int SIZE_W = 9;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 9'd256;

    // free-slot search runs over groups of this many slots
    localparam int GROUP = 16;
    localparam int GROUP_W = 4;

    localparam logic [1:0] KIND_ALLOC_FIRST = 2'd0;
    localparam logic [1:0] KIND_ALLOC_AT    = 2'd1;
    localparam logic [1:0] KIND_READ        = 2'd2;
    localparam logic [1:0] KIND_FREE        = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  index;
        logic [63:0] entry;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  handle;
        logic [63:0] found_entry;
    } rsp_t;

endpackage

// ----- rtl/core/handle_slot_allocator_core.sv -----
// handle slot allocator: start is registered into the execute state, which raises the done strobe, for every kind
// the slot memory is read at accept and written back in the execute cycle
// busy is high for the one execute cycle, so a new item can start in the cycle done is shown
// done pulses for one cycle; the receiver cannot stall
// reset empties every slot at once through the occupancy bits and sets table_size to 256
module handle_slot_allocator_core
    import hsa_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    `include "assert_macros.svh"

    // only the lowest 256 slots can be named by a handle
    localparam int DEPTH   = (SLOTS > 256) ? 256 : SLOTS;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int PAD     = NGROUPS * GROUP;
    localparam int FW      = GW + GROUP_W;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0]        state_reg;
    logic [SIZE_W-1:0] table_size_reg;
    logic [DEPTH-1:0]  occ_reg;
    req_t              req_reg;
    logic [63:0]       rd_data_reg;
    logic [GW-1:0]     grp_sel_reg;
    logic              grp_any_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic [63:0]       mem [DEPTH];

    logic              accept;
    logic [SIZE_W-1:0] usable;
    logic [PAD-1:0]    occ_pad;
    logic [PAD-1:0]    free_pad;
    logic [NGROUPS-1:0] grp_free;
    logic [GW-1:0]     grp_next;
    logic              grp_any_next;

    logic              in_range;
    logic              slot_used;
    logic [GROUP-1:0]  grp_bits;
    logic [GROUP_W-1:0] bit_sel;
    logic [FW-1:0]     first_full;
    logic              mem_we;
    logic [IDX_W-1:0]  waddr;
    logic              set_bit;
    logic              clr_bit;
    rsp_t              rsp_next;

    logic              grant_seen;
    logic              grant_bit;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign usable  = (table_size_reg > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : table_size_reg;
    assign occ_pad = PAD'(occ_reg);

    // successful allocation on show and the occupancy bit of its slot
    assign grant_seen = done_reg && (rsp_reg.status == ST_OK)
                        && (req_reg.kind == KIND_ALLOC_FIRST || req_reg.kind == KIND_ALLOC_AT);
    assign grant_bit  = occ_reg[rsp_reg.handle[IDX_W-1:0]];

    // free map of usable slots and lowest group holding a free one
    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            free_pad[i] = !occ_pad[i] && (SIZE_W'(i) < usable);
        end
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_free[g] = |free_pad[g*GROUP +: GROUP];
        end
        grp_next = '0;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_next = GW'(g);
            end
        end
        grp_any_next = |grp_free;
    end

    // execute: decide the result and the table update
    always_comb
    begin
        in_range  = {1'b0, req_reg.index} < usable;
        slot_used = in_range && occ_reg[req_reg.index[IDX_W-1:0]];
        grp_bits  = free_pad[{grp_sel_reg, GROUP_W'(0)} +: GROUP];
        bit_sel   = '0;
        for (int b = GROUP - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_sel = GROUP_W'(b);
            end
        end
        first_full = {grp_sel_reg, bit_sel};

        rsp_next.status      = ST_OK;
        rsp_next.handle      = '0;
        rsp_next.found_entry = '0;
        mem_we  = 1'b0;
        waddr   = req_reg.index[IDX_W-1:0];
        set_bit = 1'b0;
        clr_bit = 1'b0;

        unique case (req_reg.kind)
            KIND_ALLOC_FIRST:
            begin
                if (req_reg.entry == '0)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (!grp_any_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else
                begin
                    mem_we          = 1'b1;
                    set_bit         = 1'b1;
                    waddr           = first_full[IDX_W-1:0];
                    rsp_next.handle = 8'(first_full);
                end
            end
            KIND_ALLOC_AT:
            begin
                if (req_reg.entry == '0 || !in_range)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (slot_used)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else
                begin
                    mem_we          = 1'b1;
                    set_bit         = 1'b1;
                    rsp_next.handle = req_reg.index;
                end
            end
            KIND_READ:
            begin
                if (!in_range)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (slot_used)
                begin
                    rsp_next.found_entry = rd_data_reg;
                end
            end
            KIND_FREE:
            begin
                if (!slot_used)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else
                begin
                    clr_bit = 1'b1;
                end
            end
        endcase
    end

    // slot memory: read at accept, written back in the execute cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && mem_we)
        begin
            mem[waddr] <= req_reg.entry;
        end
        if (accept)
        begin
            rd_data_reg <= mem[req.index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= req;
            grp_sel_reg <= grp_next;
            grp_any_reg <= grp_any_next;
        end
        if (state_reg == S_EXEC)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            occ_reg        <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else
        begin
            done_reg <= (state_reg == S_EXEC);
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    if (set_bit)
                    begin
                        occ_reg[waddr] <= 1'b1;
                    end
                    if (clr_bit)
                    begin
                        occ_reg[req_reg.index[IDX_W-1:0]] <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_accept_goes_busy, accept |=> busy, "accepted item did not raise busy")
    `ASSERT_CLK(a_exec_gives_done, (state_reg == S_EXEC) |=> done_reg, "execute gave no done")
    `ASSERT_CLK(a_done_when_idle, done_reg |-> (state_reg == S_IDLE), "done while busy")
    `ASSERT_CLK(a_alloc_marks_slot, grant_seen |-> grant_bit, "granted slot not marked used")

endmodule
